/* hdl/dtfs_pkg.sv */
`timescale 1ns / 1ps

package dtfs_pkg;

    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] LF_BYTE     = 8'h0A;
    localparam logic [7:0] CR_BYTE     = 8'h0D;
    localparam logic [7:0] DELIM_RESET = 8'h2C;

    // item kind carried in tuser on the input side
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // quote tracking; code 3 is never reached and behaves as outside
    localparam logic [1:0] QM_OUT     = 2'd0;
    localparam logic [1:0] QM_IN      = 2'd1;
    localparam logic [1:0] QM_AFTER_Q = 2'd2;

    typedef enum logic [1:0] {
        EV_CHAR  = 2'd0,
        EV_FIELD = 2'd1,
        EV_ROW   = 2'd2
    } t_event;

    typedef struct packed {
        logic [1:0] quote_mode;
        logic       field_nonempty;
        logic       row_begun;
        logic       after_cr;
    } t_state;

    typedef struct packed {
        logic       valid;
        t_event     ev;
        logic [7:0] char_out;
    } t_result;

endpackage

/* hdl/dtfs_step.sv */
`timescale 1ns / 1ps

module dtfs_step (
    input  dtfs_pkg::t_state  i_state,
    input  logic              i_kind,
    input  logic [7:0]        i_ch,
    input  logic [7:0]        i_delim,
    output dtfs_pkg::t_state  o_state,
    output dtfs_pkg::t_result o_res
);

    dtfs_pkg::t_state n_st;
    dtfs_pkg::t_event ev;
    logic             emit;
    logic             is_quote;
    logic             is_delim;
    logic             is_lf;
    logic             is_cr;

    assign is_quote = (i_ch == dtfs_pkg::QUOTE_BYTE);
    assign is_delim = (i_ch == i_delim);
    assign is_lf    = (i_ch == dtfs_pkg::LF_BYTE);
    assign is_cr    = (i_ch == dtfs_pkg::CR_BYTE);

    always_comb begin
        n_st = i_state;
        emit = 1'b0;
        ev   = dtfs_pkg::EV_CHAR;

        if (i_kind == dtfs_pkg::KIND_EOS) begin
            n_st = '0;
            if (i_state.row_begun) begin
                emit = 1'b1;
                ev   = dtfs_pkg::EV_ROW;
            end
        end else begin
            n_st.after_cr = 1'b0;
            // LF right after a row-ending CR is swallowed
            if (!(i_state.after_cr && is_lf)) begin
                n_st.row_begun = 1'b1;
                case (i_state.quote_mode)
                    dtfs_pkg::QM_IN: begin
                        if (is_quote) begin
                            n_st.quote_mode = dtfs_pkg::QM_AFTER_Q;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                    dtfs_pkg::QM_AFTER_Q: begin
                        emit = 1'b1;
                        if (is_quote) begin
                            n_st.quote_mode = dtfs_pkg::QM_IN;
                        end else begin
                            n_st.quote_mode = dtfs_pkg::QM_OUT;
                            if (is_delim) begin
                                ev = dtfs_pkg::EV_FIELD;
                            end else if (is_lf) begin
                                ev = dtfs_pkg::EV_ROW;
                            end else if (is_cr) begin
                                ev = dtfs_pkg::EV_ROW;
                                n_st.after_cr = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_st.quote_mode = dtfs_pkg::QM_OUT;
                        if (is_quote && !i_state.field_nonempty) begin
                            n_st.quote_mode = dtfs_pkg::QM_IN;
                        end else begin
                            emit = 1'b1;
                            if (is_delim) begin
                                ev = dtfs_pkg::EV_FIELD;
                            end else if (is_lf) begin
                                ev = dtfs_pkg::EV_ROW;
                            end else if (is_cr) begin
                                ev = dtfs_pkg::EV_ROW;
                                n_st.after_cr = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        // side effects of emitting a result
        if (emit) begin
            n_st.field_nonempty = (ev == dtfs_pkg::EV_CHAR);
            if (ev == dtfs_pkg::EV_ROW) begin
                n_st.quote_mode = dtfs_pkg::QM_OUT;
                n_st.row_begun  = 1'b0;
            end
        end
    end

    assign o_state        = n_st;
    assign o_res.valid    = emit;
    assign o_res.ev       = ev;
    assign o_res.char_out = (ev == dtfs_pkg::EV_CHAR) ? i_ch : 8'h00;

endmodule

/* hdl/delimited_text_field_splitter.sv */
`timescale 1ns / 1ps
// A beat accepted into the input register is parsed by the combinational step into the output
// register once that register is free, and its result is then offered from the output register.
// Throughput: one beat per cycle while the output is not stalled; the combinational parser step
// between the input and output registers sets that figure, also for beats that give no result.
// Reset (i_rst_n low, synchronous): both registers empty, parser state cleared, delimiter ','.

module delimited_text_field_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] ch
    input  logic       i_s_axis_tuser,   // [0] kind
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] char_out
    output logic [1:0] o_m_axis_tuser    // [1:0] event_res
);

    logic              r_in_valid;
    logic              r_in_kind;
    logic [7:0]        r_in_ch;
    logic [7:0]        r_delim;
    dtfs_pkg::t_state  r_state;
    dtfs_pkg::t_state  n_state;
    dtfs_pkg::t_result step_res;
    logic              r_out_valid;
    logic [1:0]        r_out_ev;
    logic [7:0]        r_out_ch;
    logic              out_free;
    logic              s1_adv;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_adv          = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    dtfs_step u_step (
        .i_state (r_state),
        .i_kind  (r_in_kind),
        .i_ch    (r_in_ch),
        .i_delim (r_delim),
        .o_state (n_state),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_delim     <= dtfs_pkg::DELIM_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_delim <= i_cfg_wr_data;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (s1_adv) begin
                r_state     <= n_state;
                r_out_valid <= step_res.valid;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind <= i_s_axis_tuser;
            r_in_ch   <= i_s_axis_tdata;
        end
        if (s1_adv && step_res.valid) begin
            r_out_ev <= step_res.ev;
            r_out_ch <= step_res.char_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_ch;
    assign o_m_axis_tuser  = r_out_ev;

    a_row_end_clears_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && step_res.valid && step_res.ev == dtfs_pkg::EV_ROW
        |=> !r_state.row_begun && r_state.quote_mode == dtfs_pkg::QM_OUT)
        else $error("row end left row state set");

    a_eos_resets_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_in_kind == dtfs_pkg::KIND_EOS |=> r_state == '0)
        else $error("end of stream did not clear parser state");

    a_event_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ev != dtfs_pkg::EV_CHAR |-> r_out_ch == 8'h00)
        else $error("field or row end carries a nonzero char");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && r_out_valid && !i_m_axis_tready)
        else $error("input stalled while a register was free");

endmodule
